// ----- src/pfbd_pkg.sv -----
// Shared constants, codes and controller/datapath types for the page frame buffer.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none
package pfbd_pkg;

  localparam int COLUMN_COUNT = 128;
  localparam int PAGES        = 8;
  localparam int ROW_COUNT    = PAGES * 8;
  localparam int CELL_COUNT   = PAGES * COLUMN_COUNT;

  localparam int CELL_AW = $clog2(CELL_COUNT);
  localparam int COL_CW  = $clog2(COLUMN_COUNT);
  localparam int PAGE_CW = (PAGES > 1) ? $clog2(PAGES) : 1;

  // field widths of the channels
  localparam int ACTION_W = 2;
  localparam int X_W      = 7;
  localparam int Y_W      = 6;
  localparam int PAGE_W   = 3;
  localparam int COL_W    = 7;
  localparam int DATA_W   = 8;

  // memory word: dirty flag above the pixel byte
  localparam int WORD_W = DATA_W + 1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_WRITE = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_FETCH = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  typedef enum logic {
    RD_PTR,
    RD_PIXEL
  } rd_src_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_INIT,
    WR_PIXEL,
    WR_CLEAR,
    WR_FETCH
  } wr_sel_e;

  typedef struct packed {
    logic    item_load;
    logic    ptr_clr;
    logic    ptr_inc;
    logic    rd_en;
    rd_src_e rd_src;
    wr_sel_e wr_sel;
    logic    out_load;
    logic    out_found;
  } cmd_t;

  typedef struct packed {
    logic ptr_last;
    logic lag_last;
    logic rd_dirty;
    logic rd_nonzero;
    logic pix_in_range;
    logic pix_changed;
  } sts_t;

endpackage
`default_nettype wire

// ----- src/pfbd_if.sv -----
// Valid/ready channel interfaces for pixel requests and fetch results.
// Depends on pfbd_pkg for field widths.
`default_nettype none
interface pfbd_in_if;
  logic                          valid;
  logic                          ready;
  logic [pfbd_pkg::ACTION_W-1:0] action;
  logic [pfbd_pkg::X_W-1:0]      x;
  logic [pfbd_pkg::Y_W-1:0]      y;
  logic                          pixel_on;

  modport source (output valid, action, x, y, pixel_on, input ready);
  modport sink   (input valid, action, x, y, pixel_on, output ready);
endinterface

interface pfbd_out_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [pfbd_pkg::PAGE_W-1:0] page_index;
  logic [pfbd_pkg::COL_W-1:0]  column_index;
  logic [pfbd_pkg::DATA_W-1:0] change_data;

  modport source (output valid, found, page_index, column_index, change_data, input ready);
  modport sink   (input valid, found, page_index, column_index, change_data, output ready);
endinterface
`default_nettype wire

// ----- src/pfbd_ctrl.sv -----
// Sequencer for the frame buffer: init sweep, pixel read-modify-write, clear and fetch scans.
// Depends on pfbd_pkg; drives pfbd_datapath through cmd_t and reads sts_t.
`default_nettype none
module pfbd_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [pfbd_pkg::ACTION_W-1:0] action_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  input  wire pfbd_pkg::sts_t                sts_i,
  output pfbd_pkg::cmd_t                     cmd_o
);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_CLR,
    ST_FET,
    ST_FET_OUT
  } state_e;

  state_e state_q, state_d;
  logic   prime_q, prime_d;     // read data register holds a scanned word
  logic   found_q, found_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    state_d     = state_q;
    prime_d     = prime_q;
    found_d     = found_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_INIT: begin
        cmd_o.wr_sel  = pfbd_pkg::WR_INIT;
        cmd_o.ptr_inc = 1'b1;
        if (sts_i.ptr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.item_load = 1'b1;
          cmd_o.ptr_clr   = 1'b1;
          prime_d         = 1'b0;
          case (pfbd_pkg::action_e'(action_i))
            pfbd_pkg::ACT_WRITE: state_d = ST_PIX_RD;
            pfbd_pkg::ACT_CLEAR: state_d = ST_CLR;
            pfbd_pkg::ACT_FETCH: state_d = ST_FET;
            default:             state_d = ST_IDLE;
          endcase
        end
      end
      ST_PIX_RD: begin
        if (sts_i.pix_in_range) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_src = pfbd_pkg::RD_PIXEL;
          state_d      = ST_PIX_WR;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_PIX_WR: begin
        if (sts_i.pix_changed) begin
          cmd_o.wr_sel = pfbd_pkg::WR_PIXEL;
        end
        state_d = ST_IDLE;
      end
      ST_CLR: begin
        if (prime_q && sts_i.rd_nonzero) begin
          cmd_o.wr_sel = pfbd_pkg::WR_CLEAR;
        end
        if (prime_q && sts_i.lag_last) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_src  = pfbd_pkg::RD_PTR;
          cmd_o.ptr_inc = 1'b1;
          prime_d       = 1'b1;
        end
      end
      ST_FET: begin
        if (prime_q && sts_i.rd_dirty) begin
          cmd_o.wr_sel = pfbd_pkg::WR_FETCH;
          found_d      = 1'b1;
          state_d      = ST_FET_OUT;
        end else if (prime_q && sts_i.lag_last) begin
          found_d = 1'b0;
          state_d = ST_FET_OUT;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_src  = pfbd_pkg::RD_PTR;
          cmd_o.ptr_inc = 1'b1;
          prime_d       = 1'b1;
        end
      end
      ST_FET_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.out_found = found_q;
          out_valid_d     = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      prime_q     <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prime_q     <= prime_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ----- src/pfbd_datapath.sv -----
// Frame/dirty memory, scan pointer, pixel item registers and result register.
// Depends on pfbd_pkg; commanded by pfbd_ctrl.
`default_nettype none
module pfbd_datapath (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire pfbd_pkg::cmd_t              cmd_i,
  output pfbd_pkg::sts_t                   sts_o,
  input  wire logic [pfbd_pkg::X_W-1:0]    x_i,
  input  wire logic [pfbd_pkg::Y_W-1:0]    y_i,
  input  wire logic                        pixel_on_i,
  output logic                             found_o,
  output logic [pfbd_pkg::PAGE_W-1:0]      page_index_o,
  output logic [pfbd_pkg::COL_W-1:0]       column_index_o,
  output logic [pfbd_pkg::DATA_W-1:0]      change_data_o
);

  localparam int AW  = pfbd_pkg::CELL_AW;
  localparam int CW  = pfbd_pkg::COL_CW;
  localparam int PW  = pfbd_pkg::PAGE_CW;
  localparam int DW  = pfbd_pkg::DATA_W;
  localparam int WW  = pfbd_pkg::WORD_W;
  localparam int MW  = AW + 8;
  localparam logic [AW-1:0] LAST_CELL = AW'(pfbd_pkg::CELL_COUNT - 1);

  // word = {dirty, byte}
  logic [WW-1:0] mem_q [pfbd_pkg::CELL_COUNT];
  logic [WW-1:0] rd_q;

  // pixel request
  logic [AW-1:0] pix_addr_q;
  logic [2:0]    bit_q;
  logic          on_q;
  logic          in_range_q;
  logic [MW-1:0] pix_addr_w;

  // scan pointer and its value at the last read into rd_q
  logic [AW-1:0] ptr_q, lag_q;
  logic [CW-1:0] ptr_col_q, lag_col_q;
  logic [PW-1:0] ptr_page_q, lag_page_q;

  logic [AW-1:0] rd_addr, wr_addr;
  logic [WW-1:0] wr_data;
  logic          wr_en;
  logic [DW-1:0] bit_mask, new_byte;
  logic [PW+pfbd_pkg::PAGE_W-1:0] page_ext;
  logic [CW+pfbd_pkg::COL_W-1:0]  col_ext;

  assign pix_addr_w = MW'(y_i >> 3) * MW'(pfbd_pkg::COLUMN_COUNT) + MW'(x_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) begin
      pix_addr_q <= pix_addr_w[AW-1:0];
      bit_q      <= y_i[2:0];
      on_q       <= pixel_on_i;
      in_range_q <= (int'(x_i) < pfbd_pkg::COLUMN_COUNT) && (int'(y_i) < pfbd_pkg::ROW_COUNT);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q      <= '0;
      ptr_col_q  <= '0;
      ptr_page_q <= '0;
    end else if (cmd_i.ptr_clr) begin
      ptr_q      <= '0;
      ptr_col_q  <= '0;
      ptr_page_q <= '0;
    end else if (cmd_i.ptr_inc) begin
      ptr_q <= (ptr_q == LAST_CELL) ? '0 : ptr_q + AW'(1);
      if (ptr_col_q == CW'(pfbd_pkg::COLUMN_COUNT - 1)) begin
        ptr_col_q  <= '0;
        ptr_page_q <= (ptr_page_q == PW'(pfbd_pkg::PAGES - 1)) ? '0 : ptr_page_q + PW'(1);
      end else begin
        ptr_col_q <= ptr_col_q + CW'(1);
      end
    end
  end

  assign rd_addr = (cmd_i.rd_src == pfbd_pkg::RD_PIXEL) ? pix_addr_q : ptr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_q       <= mem_q[rd_addr];
      lag_q      <= ptr_q;
      lag_col_q  <= ptr_col_q;
      lag_page_q <= ptr_page_q;
    end
  end

  assign bit_mask = DW'(1) << bit_q;
  assign new_byte = on_q ? (rd_q[DW-1:0] | bit_mask) : (rd_q[DW-1:0] & ~bit_mask);

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = lag_q;
    wr_data = '0;
    case (cmd_i.wr_sel)
      pfbd_pkg::WR_INIT: begin
        wr_addr = ptr_q;
      end
      pfbd_pkg::WR_PIXEL: begin
        wr_addr = pix_addr_q;
        wr_data = {1'b1, new_byte};
      end
      pfbd_pkg::WR_CLEAR: begin
        wr_data = {1'b1, {DW{1'b0}}};
      end
      pfbd_pkg::WR_FETCH: begin
        wr_data = {1'b0, rd_q[DW-1:0]};
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  // index fields wrap to their port widths
  assign page_ext = {{pfbd_pkg::PAGE_W{1'b0}}, lag_page_q};
  assign col_ext  = {{pfbd_pkg::COL_W{1'b0}}, lag_col_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      found_o        <= cmd_i.out_found;
      page_index_o   <= cmd_i.out_found ? page_ext[pfbd_pkg::PAGE_W-1:0] : '0;
      column_index_o <= cmd_i.out_found ? col_ext[pfbd_pkg::COL_W-1:0] : '0;
      change_data_o  <= cmd_i.out_found ? rd_q[DW-1:0] : '0;
    end
  end

  assign sts_o.ptr_last     = (ptr_q == LAST_CELL);
  assign sts_o.lag_last     = (lag_q == LAST_CELL);
  assign sts_o.rd_dirty     = rd_q[WW-1];
  assign sts_o.rd_nonzero   = |rd_q[DW-1:0];
  assign sts_o.pix_in_range = in_range_q;
  assign sts_o.pix_changed  = (rd_q[bit_q] != on_q);

endmodule
`default_nettype wire

// ----- src/page_frame_buffer_dirty_tracker_unit.sv -----
// Top level of the page-layout monochrome frame buffer with per-byte dirty tracking.
// Depends on pfbd_pkg, pfbd_if, pfbd_ctrl and pfbd_datapath.
//
// A pixel byte lives at page*COLUMN_COUNT+column (page = y/8, bit = y%8) in one
// single-port-write, single-port-read memory whose word also carries that byte's
// dirty flag. After reset the block sweeps all CELL_COUNT words (1024 in this
// build) to zero, one word a cycle; no request is taken until then.
// Per request: a pixel write reads, then writes back the modified byte; clear
// screen reads one word a cycle with zeroing writes overlapped; fetch scans
// for the first dirty byte in page-major, column order (to the end when none
// is dirty), then may wait for the result register to drain. The scan is bound
// by the one memory read port. Actions other than write, clear and fetch are
// accepted and ignored.
`default_nettype none
module page_frame_buffer_dirty_tracker_unit (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pfbd_in_if.sink    req_i,
  pfbd_out_if.source rsp_o
);

  pfbd_pkg::cmd_t cmd;
  pfbd_pkg::sts_t sts;

  // controller owns the handshakes and the sequencing
  pfbd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .action_i    (req_i.action),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // memory, scan pointer and result register
  pfbd_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .x_i            (req_i.x),
    .y_i            (req_i.y),
    .pixel_on_i     (req_i.pixel_on),
    .found_o        (rsp_o.found),
    .page_index_o   (rsp_o.page_index),
    .column_index_o (rsp_o.column_index),
    .change_data_o  (rsp_o.change_data)
  );

endmodule
`default_nettype wire

// ----- src/pfbd_checker.sv -----
// Port-level assertions for page_frame_buffer_dirty_tracker_unit, attached by bind.
// Depends on pfbd_pkg for action codes.
`default_nettype none
module pfbd_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_i,
  input wire logic [pfbd_pkg::ACTION_W-1:0] action_i,
  input wire logic                          out_valid_i,
  input wire logic                          out_ready_i,
  input wire logic                          found_i,
  input wire logic [pfbd_pkg::PAGE_W-1:0]   page_index_i,
  input wire logic [pfbd_pkg::COL_W-1:0]    column_index_i,
  input wire logic [pfbd_pkg::DATA_W-1:0]   change_data_i
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(found_i) &&
      $stable(page_index_i) && $stable(column_index_i) && $stable(change_data_i)))
    else $error("stalled result changed");

  // an empty fetch reports all-zero fields
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !found_i) |->
      (page_index_i == '0 && column_index_i == '0 && change_data_i == '0))
    else $error("empty fetch with nonzero fields");

  // any real action keeps the block busy for at least the next cycle
  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && action_i != pfbd_pkg::ACT_NOP) |=> !in_ready_i)
    else $error("request taken while previous action in progress");

endmodule

bind page_frame_buffer_dirty_tracker_unit pfbd_checker u_pfbd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (req_i.valid),
  .in_ready_i     (req_i.ready),
  .action_i       (req_i.action),
  .out_valid_i    (rsp_o.valid),
  .out_ready_i    (rsp_o.ready),
  .found_i        (rsp_o.found),
  .page_index_i   (rsp_o.page_index),
  .column_index_i (rsp_o.column_index),
  .change_data_i  (rsp_o.change_data)
);
`default_nettype wire
